// ===== src/wsd_pkg.sv =====
// Shared types and constants for the wheel sync PD drive controller.
// No dependencies; imported by every module of the block.
package wsd_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int POWER_W        = 24;   // follower power, signed Q7.16
    localparam int POWER_LIMIT    = 100 * 65536;

    localparam logic [15:0] P_GAIN_RESET = 16'd410;
    localparam logic [15:0] D_GAIN_RESET = 16'd13107;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MASTER_POWER = 2'd0,
        REG_TICK_GOAL    = 2'd1,
        REG_P_GAIN       = 2'd2,
        REG_D_GAIN       = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic signed [7:0] master_power;
        logic [15:0]       tick_goal;
        logic [15:0]       p_gain;
        logic [15:0]       d_gain;
    } cfg_t;

endpackage

// ===== src/wsd_cfg.sv =====
// Configuration register file for the wheel sync PD drive controller.
// Depends on wsd_pkg.
module wsd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [wsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wsd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output wsd_pkg::cfg_t                       cfg
);
    import wsd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.master_power <= '0;
            cfg_reg.tick_goal    <= '0;
            cfg_reg.p_gain       <= P_GAIN_RESET;
            cfg_reg.d_gain       <= D_GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_MASTER_POWER: cfg_reg.master_power <= cfg_data[7:0];
                REG_TICK_GOAL:    cfg_reg.tick_goal    <= cfg_data[15:0];
                REG_P_GAIN:       cfg_reg.p_gain       <= cfg_data[15:0];
                REG_D_GAIN:       cfg_reg.d_gain       <= cfg_data[15:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/wsd_law.sv =====
// PD control law: next follower power, error history and done flag for one word.
// Depends on wsd_pkg.
module wsd_law #(
    parameter int COUNT_BITS = wsd_pkg::COUNT_BITS_DEF
) (
    input  logic                                  cmd,
    input  logic [COUNT_BITS-1:0]                 left_count,
    input  logic [COUNT_BITS-1:0]                 right_count,
    input  wsd_pkg::cfg_t                         cfg,
    input  logic signed [wsd_pkg::POWER_W-1:0]    power,
    input  logic signed [COUNT_BITS:0]            prev_err,
    input  logic                                  done,
    output logic signed [wsd_pkg::POWER_W-1:0]    power_next,
    output logic signed [COUNT_BITS:0]            prev_err_next,
    output logic                                  done_next
);
    import wsd_pkg::*;

    localparam int ERR_W  = COUNT_BITS + 1;
    localparam int DLT_W  = COUNT_BITS + 2;
    localparam int PP_W   = COUNT_BITS + 18;
    localparam int PD_W   = COUNT_BITS + 19;
    localparam int NEXT_W = COUNT_BITS + 21;
    localparam int CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic signed [NEXT_W-1:0] LIM = NEXT_W'(POWER_LIMIT);

    logic                     forward;
    logic signed [9:0]        master_ext;
    logic signed [9:0]        init_pct;
    logic signed [NEXT_W-1:0] init_q;
    logic signed [ERR_W-1:0]  err;
    logic signed [DLT_W-1:0]  delta;
    logic signed [PP_W-1:0]   err_p;
    logic signed [PP_W-1:0]   gain_p;
    logic signed [PP_W-1:0]   prod_p;
    logic signed [PD_W-1:0]   delta_d;
    logic signed [PD_W-1:0]   gain_d;
    logic signed [PD_W-1:0]   prod_d;
    logic signed [NEXT_W-1:0] term;
    logic signed [NEXT_W-1:0] power_ext;
    logic signed [NEXT_W-1:0] pre_sat;
    logic                     start;
    logic                     active;
    logic                     reached;

    assign start      = (cmd_t'(cmd) == CMD_START);
    assign active     = !start && !done;
    assign forward    = (cfg.master_power > 8'sd0);
    assign master_ext = 10'(cfg.master_power);
    assign init_pct   = forward ? (master_ext + 10'sd2) : (master_ext - 10'sd1);
    assign init_q     = NEXT_W'(signed'({init_pct, 16'h0000}));

    assign err     = signed'({1'b0, left_count}) - signed'({1'b0, right_count});
    assign delta   = DLT_W'(err) - DLT_W'(prev_err);
    assign err_p   = PP_W'(err);
    assign gain_p  = signed'(PP_W'({1'b0, cfg.p_gain}));
    assign prod_p  = err_p * gain_p;
    assign delta_d = PD_W'(delta);
    assign gain_d  = signed'(PD_W'({1'b0, cfg.d_gain}));
    assign prod_d  = delta_d * gain_d;
    assign term    = NEXT_W'(prod_p) + NEXT_W'(prod_d);

    assign power_ext = NEXT_W'(power);
    assign pre_sat   = start ? init_q
                     : (forward ? (power_ext + term) : (power_ext - term));

    assign reached = (CMP_W'(left_count) >= CMP_W'(cfg.tick_goal));

    always_comb
    begin
        power_next    = power;
        prev_err_next = prev_err;
        done_next     = done;
        if (start || active)
        begin
            if (pre_sat > LIM)
                power_next = POWER_W'(LIM);
            else if (pre_sat < -LIM)
                power_next = POWER_W'(-LIM);
            else
                power_next = POWER_W'(pre_sat);
        end
        if (start)
        begin
            prev_err_next = '0;
            done_next     = (cfg.tick_goal == 16'd0);
        end
        else if (active)
        begin
            prev_err_next = err;
            done_next     = reached;
        end
    end

endmodule

// ===== src/wheel_sync_pd_drive_core.sv =====
// Top level of the wheel sync PD drive controller: input stage, loop state, result stage.
// Depends on wsd_pkg, wsd_cfg and wsd_law.

// Each word in gives exactly one word out, via the input then the result register; a
// new word is taken every cycle while the result side keeps up. Follower power update
// (two 16-bit-gain multiplies, add, saturate) is combinational between the input and
// result registers, so consecutive samples chain through the state with no gap.
// Configuration must be written only while idle; the block does not enforce it.
module wheel_sync_pd_drive_core #(
    parameter int COUNT_BITS = wsd_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [wsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wsd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               cmd,
    input  logic [COUNT_BITS-1:0]              left_count,
    input  logic [COUNT_BITS-1:0]              right_count,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [7:0]                  left_drive,
    output logic signed [15:0]                 right_drive,
    output logic                               finished
);
    import wsd_pkg::*;

    cfg_t cfg;

    logic                        s1_valid_reg;
    logic                        s1_cmd_reg;
    logic [COUNT_BITS-1:0]       s1_left_reg;
    logic [COUNT_BITS-1:0]       s1_right_reg;
    logic                        s1_advance;

    logic signed [POWER_W-1:0]   power_reg;
    logic signed [COUNT_BITS:0]  prev_err_reg;
    logic                        done_reg;
    logic signed [POWER_W-1:0]   power_next;
    logic signed [COUNT_BITS:0]  prev_err_next;
    logic                        done_next;

    logic                        res_valid_reg;
    logic signed [7:0]           res_left_reg;
    logic signed [15:0]          res_right_reg;
    logic                        res_fin_reg;
    logic signed [POWER_W-1:0]   power_shr;

    wsd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wsd_law #(
        .COUNT_BITS (COUNT_BITS)
    ) u_law (
        .cmd           (s1_cmd_reg),
        .left_count    (s1_left_reg),
        .right_count   (s1_right_reg),
        .cfg           (cfg),
        .power         (power_reg),
        .prev_err      (prev_err_reg),
        .done          (done_reg),
        .power_next    (power_next),
        .prev_err_next (prev_err_next),
        .done_next     (done_next)
    );

    assign s1_advance = s1_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_advance;
    assign power_shr  = power_next >>> 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            power_reg     <= '0;
            prev_err_reg  <= '0;
            done_reg      <= 1'b1;
        end
        else
        begin
            if (item_ready)
                s1_valid_reg <= item_valid;
            if (s1_advance)
            begin
                res_valid_reg <= 1'b1;
                power_reg     <= power_next;
                prev_err_reg  <= prev_err_next;
                done_reg      <= done_next;
            end
            else if (result_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            s1_cmd_reg   <= cmd;
            s1_left_reg  <= left_count;
            s1_right_reg <= right_count;
        end
        if (s1_advance)
        begin
            res_fin_reg   <= done_next;
            res_left_reg  <= done_next ? 8'sd0 : cfg.master_power;
            res_right_reg <= done_next ? 16'sd0 : power_shr[15:0];
        end
    end

    assign result_valid = res_valid_reg;
    assign left_drive   = res_left_reg;
    assign right_drive  = res_right_reg;
    assign finished     = res_fin_reg;

`ifndef SYNTHESIS
    a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && finished |-> (left_drive == 8'sd0) && (right_drive == 16'sd0))
        else $error("finished word carries nonzero drive");

    a_power_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (power_reg <= POWER_W'(POWER_LIMIT)) && (power_reg >= -POWER_W'(POWER_LIMIT)))
        else $error("follower power out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> s1_valid_reg && res_valid_reg && !result_ready)
        else $error("input stalled without a full pipeline");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(power_reg) && $stable(done_reg))
        else $error("loop state changed without a word");
`endif

endmodule
